/* rtl/core/gtp_pkg.sv */
// Shared types, widths and constants for the go-to-point steering block.
// No dependencies; imported by every module of the block.
`default_nettype none

package gtp_pkg;

	// field widths
	localparam int POS_W   = 16;  // Q5.10 positions
	localparam int ANG_W   = 15;  // Q2.12 heading
	localparam int SPD_W   = 15;  // Q5.10 speed
	localparam int TOL_W   = 15;  // Q5.10 arrival radius
	localparam int HTOL_W  = 14;  // Q2.12 heading tolerance
	localparam int RATE_W  = 16;  // Q5.10 turn rate
	localparam int MODE_W  = 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_X  = 3'd0,
		REG_TARGET_Y  = 3'd1,
		REG_CRUISE    = 3'd2,
		REG_DIST_TOL  = 3'd3,
		REG_HEAD_TOL  = 3'd4
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ARRIVED = 2'd0,
		MODE_TURN    = 2'd1,
		MODE_DRIVE   = 2'd2
	} mode_t;

	// CORDIC
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_IDX_W    = 5;   // stage index width for the atan table
	localparam int DIFF_W        = POS_W + 1;
	localparam int PRESHIFT      = 12;
	localparam int CX_W          = 32;
	localparam int CZ_W          = 20;
	localparam logic signed [CZ_W-1:0] HALF_PI_Z = CZ_W'(102944);

	// arrival test
	localparam int SQ_W  = 2 * DIFF_W;
	localparam int DSQ_W = SQ_W + 1;
	localparam int TSQ_W = 2 * TOL_W;

	// heading error, Q16 radians
	localparam int ERR_W   = 21;
	localparam int ERR_SH  = 4;     // Q16 -> Q12
	localparam logic signed [ERR_W-1:0] PI_Q16     = ERR_W'(205887);
	localparam logic signed [ERR_W-1:0] TWO_PI_Q16 = ERR_W'(411775);
	localparam logic signed [ERR_W-1:0] ERR_RND    = ERR_W'(8);

	// turn rate
	localparam int E12_W     = 16;
	localparam int TURN_GAIN = 10;
	localparam int RP_W      = 22;
	localparam int RATE_SH   = 2;   // gain / 4
	localparam logic signed [RP_W-1:0] RATE_RND   = RP_W'(2);
	localparam logic signed [RP_W-1:0] RATE_LIMIT = RP_W'(32170);

	typedef struct packed {
		logic signed [CX_W-1:0]  x;
		logic signed [CX_W-1:0]  y;
		logic signed [CZ_W-1:0]  z;
		logic signed [ANG_W-1:0] theta;
		logic                    arrived;
		logic                    zero_vec;
	} cell_word_t;

	// atan(2^-i) in Q16, rounded; zero beyond i = 16
	function automatic logic signed [CZ_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] i);
		logic signed [CZ_W-1:0] a;
		case (i)
			5'd0:    a = CZ_W'(51472);
			5'd1:    a = CZ_W'(30386);
			5'd2:    a = CZ_W'(16055);
			5'd3:    a = CZ_W'(8150);
			5'd4:    a = CZ_W'(4091);
			5'd5:    a = CZ_W'(2047);
			5'd6:    a = CZ_W'(1024);
			5'd7:    a = CZ_W'(512);
			5'd8:    a = CZ_W'(256);
			5'd9:    a = CZ_W'(128);
			5'd10:   a = CZ_W'(64);
			5'd11:   a = CZ_W'(32);
			5'd12:   a = CZ_W'(16);
			5'd13:   a = CZ_W'(8);
			5'd14:   a = CZ_W'(4);
			5'd15:   a = CZ_W'(2);
			5'd16:   a = CZ_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/gtp_prep.sv */
// Front end: offset to target, squared range test and CORDIC pre-rotation.
// Three register stages. Depends on gtp_pkg.
`default_nettype none

module gtp_prep import gtp_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    in_valid,
	input  wire logic signed [POS_W-1:0] pose_x,
	input  wire logic signed [POS_W-1:0] pose_y,
	input  wire logic signed [ANG_W-1:0] pose_theta,
	input  wire logic signed [POS_W-1:0] goal_x,
	input  wire logic signed [POS_W-1:0] goal_y,
	input  wire logic [TOL_W-1:0]        arrive_radius,
	output logic                         out_valid,
	output cell_word_t                   out_word
);

	logic signed [DIFF_W-1:0] dx_c, dy_c;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic signed [ANG_W-1:0]  th_s1;
	logic                     v_s1;

	logic signed [SQ_W-1:0]   dxe, dye;
	logic signed [CX_W-1:0]   xe, ye;
	cell_word_t               rot_c;

	logic [SQ_W-1:0]          dxsq_s2, dysq_s2;
	logic [TSQ_W-1:0]         tolsq_s2;
	cell_word_t               word_s2;
	logic                     v_s2;

	cell_word_t               word_c;
	cell_word_t               word_s3;
	logic                     v_s3;

	assign dx_c = DIFF_W'(goal_x) - DIFF_W'(pose_x);
	assign dy_c = DIFF_W'(goal_y) - DIFF_W'(pose_y);

	assign dxe = SQ_W'(dx_s1);
	assign dye = SQ_W'(dy_s1);
	assign xe  = CX_W'(dx_s1) <<< PRESHIFT;
	assign ye  = CX_W'(dy_s1) <<< PRESHIFT;

	// left half plane: quarter turn first so the rotations converge
	always_comb begin
		rot_c          = '0;
		rot_c.x        = xe;
		rot_c.y        = ye;
		rot_c.z        = '0;
		rot_c.theta    = th_s1;
		rot_c.arrived  = 1'b0;
		rot_c.zero_vec = (dx_s1 == '0) && (dy_s1 == '0);
		if (xe[CX_W-1]) begin
			if (!ye[CX_W-1]) begin
				rot_c.x = ye;
				rot_c.y = -xe;
				rot_c.z = HALF_PI_Z;
			end else begin
				rot_c.x = -ye;
				rot_c.y = xe;
				rot_c.z = -HALF_PI_Z;
			end
		end
	end

	always_comb begin
		word_c         = word_s2;
		word_c.arrived = (DSQ_W'(dxsq_s2) + DSQ_W'(dysq_s2)) < DSQ_W'(tolsq_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1    <= dx_c;
			dy_s1    <= dy_c;
			th_s1    <= pose_theta;
			dxsq_s2  <= SQ_W'(dxe * dxe);
			dysq_s2  <= SQ_W'(dye * dye);
			tolsq_s2 <= TSQ_W'(arrive_radius) * TSQ_W'(arrive_radius);
			word_s2  <= rot_c;
			word_s3  <= word_c;
		end
	end

	assign out_valid = v_s3;
	assign out_word  = word_s3;

endmodule

`default_nettype wire

/* rtl/core/gtp_cell.sv */
// One CORDIC vectoring cell: a single micro-rotation, registered.
// Depends on gtp_pkg (word type, atan table).
`default_nettype none

module gtp_cell import gtp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic [ATAN_IDX_W-1:0] stage_idx,
	input  wire logic                  in_valid,
	input  wire cell_word_t            in_word,
	output logic                       out_valid,
	output cell_word_t                 out_word
);

	logic signed [CX_W-1:0] xs, ys;
	logic signed [CZ_W-1:0] at;
	cell_word_t             nxt;
	cell_word_t             word_s1;
	logic                   valid_s1;

	assign xs = in_word.x >>> stage_idx;
	assign ys = in_word.y >>> stage_idx;
	assign at = atan_q16(stage_idx);

	// drive y towards zero, accumulating the angle turned through
	always_comb begin
		nxt = in_word;
		if (!in_word.y[CX_W-1]) begin
			nxt.x = in_word.x + ys;
			nxt.y = in_word.y - xs;
			nxt.z = in_word.z + at;
		end else begin
			nxt.x = in_word.x - ys;
			nxt.y = in_word.y + xs;
			nxt.z = in_word.z - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

`default_nettype wire

/* rtl/core/gtp_post.sv */
// Back end: heading error, wrap and rounding, mode choice, output register.
// Two register stages plus the output register. Depends on gtp_pkg.
`default_nettype none

module gtp_post import gtp_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire logic                     in_valid,
	input  wire cell_word_t               in_word,
	input  wire logic [SPD_W-1:0]         cruise_speed,
	input  wire logic [HTOL_W-1:0]        heading_tolerance,
	output logic                          out_valid,
	output logic [SPD_W-1:0]              linear_x,
	output logic signed [RATE_W-1:0]      angular_z,
	output mode_t                         mode
);

	logic signed [ERR_W-1:0]  bear_c, err_c, wrap_c;
	logic signed [ERR_W-1:0]  err_s1;
	logic                     arr_s1, v_s1;

	logic signed [ERR_W-1:0]  rnd_c;
	logic signed [E12_W-1:0]  e12_c;
	logic [E12_W-1:0]         mag_c;
	logic signed [E12_W-1:0]  e12_s2;
	logic                     turn_s2, arr_s2, v_s2;

	logic signed [RP_W-1:0]   prod_c, rate_c;
	logic [SPD_W-1:0]         lin_c;
	logic signed [RATE_W-1:0] ang_c;
	mode_t                    mode_c;

	logic                     valid_q;
	logic [SPD_W-1:0]         linear_q;
	logic signed [RATE_W-1:0] angular_q;
	mode_t                    mode_q;

	// bearing minus heading, wrapped once into [-pi, pi]
	assign bear_c = in_word.zero_vec ? '0 : ERR_W'(in_word.z);
	assign err_c  = bear_c - (ERR_W'(in_word.theta) <<< ERR_SH);

	always_comb begin
		wrap_c = err_c;
		if (err_c > PI_Q16) begin
			wrap_c = err_c - TWO_PI_Q16;
		end else if (err_c < -PI_Q16) begin
			wrap_c = err_c + TWO_PI_Q16;
		end
	end

	// Q16 -> Q12, half away from zero
	always_comb begin
		if (!err_s1[ERR_W-1]) begin
			rnd_c = (err_s1 + ERR_RND) >>> ERR_SH;
		end else begin
			rnd_c = -((-err_s1 + ERR_RND) >>> ERR_SH);
		end
		e12_c = E12_W'(rnd_c);
		mag_c = e12_c[E12_W-1] ? E12_W'(-e12_c) : E12_W'(e12_c);
	end

	// rate = err * gain / 4, half away from zero, then clamp
	always_comb begin
		prod_c = RP_W'(e12_s2) * RP_W'(TURN_GAIN);
		if (!prod_c[RP_W-1]) begin
			rate_c = (prod_c + RATE_RND) >>> RATE_SH;
		end else begin
			rate_c = -((-prod_c + RATE_RND) >>> RATE_SH);
		end
		if (rate_c > RATE_LIMIT) begin
			rate_c = RATE_LIMIT;
		end else if (rate_c < -RATE_LIMIT) begin
			rate_c = -RATE_LIMIT;
		end
	end

	always_comb begin
		lin_c  = '0;
		ang_c  = '0;
		mode_c = MODE_ARRIVED;
		if (arr_s2) begin
			mode_c = MODE_ARRIVED;
		end else if (turn_s2) begin
			ang_c  = RATE_W'(rate_c);
			mode_c = MODE_TURN;
		end else begin
			lin_c  = cruise_speed;
			mode_c = MODE_DRIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1    <= wrap_c;
			arr_s1    <= in_word.arrived;
			e12_s2    <= e12_c;
			turn_s2   <= mag_c > E12_W'(heading_tolerance);
			arr_s2    <= arr_s1;
			linear_q  <= lin_c;
			angular_q <= ang_c;
			mode_q    <= mode_c;
		end
	end

	assign out_valid = valid_q;
	assign linear_x  = linear_q;
	assign angular_z = angular_q;
	assign mode      = mode_q;

endmodule

`default_nettype wire

/* rtl/core/go_to_point_steering.sv */
// Go-to-point steering: range test, CORDIC bearing, turn-then-drive command.
// A pose reaches out_valid through the prep stages, one register per CORDIC cell and the post registers.
// Throughput: one word per cycle; a stalled output holds the whole pipeline.
// The pipeline depth is set by one CORDIC cell per stage plus six fixed stages.
// Reset empties the pipeline and returns the configuration registers to their reset values.
// Depends on gtp_pkg, gtp_prep, gtp_cell and gtp_post.
`default_nettype none

module go_to_point_steering import gtp_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [POS_W-1:0]  pose_x,
	input  wire logic signed [POS_W-1:0]  pose_y,
	input  wire logic signed [ANG_W-1:0]  pose_theta,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [SPD_W-1:0]              linear_x,
	output logic signed [RATE_W-1:0]      angular_z,
	output logic [MODE_W-1:0]             mode
);

	localparam logic [SPD_W-1:0]  CRUISE_RST = SPD_W'(1024);
	localparam logic [TOL_W-1:0]  DTOL_RST   = TOL_W'(102);
	localparam logic [HTOL_W-1:0] HTOL_RST   = HTOL_W'(41);

	logic signed [POS_W-1:0] goal_x_q, goal_y_q;
	logic [SPD_W-1:0]        cruise_q;
	logic [TOL_W-1:0]        dtol_q;
	logic [HTOL_W-1:0]       htol_q;

	logic       adv;
	cell_word_t chain_word [0:CORDIC_STAGES];
	logic       chain_v    [0:CORDIC_STAGES];
	mode_t      mode_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= '0;
			goal_y_q <= '0;
			cruise_q <= CRUISE_RST;
			dtol_q   <= DTOL_RST;
			htol_q   <= HTOL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TARGET_X: goal_x_q <= cfg_data;
				REG_TARGET_Y: goal_y_q <= cfg_data;
				REG_CRUISE:   cruise_q <= cfg_data[SPD_W-1:0];
				REG_DIST_TOL: dtol_q   <= cfg_data[TOL_W-1:0];
				REG_HEAD_TOL: htol_q   <= cfg_data[HTOL_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the output register is free or being emptied
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	gtp_prep u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.pose_x        (pose_x),
		.pose_y        (pose_y),
		.pose_theta    (pose_theta),
		.goal_x        (goal_x_q),
		.goal_y        (goal_y_q),
		.arrive_radius (dtol_q),
		.out_valid     (chain_v[0]),
		.out_word      (chain_word[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		gtp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.stage_idx (ATAN_IDX_W'(i)),
			.in_valid  (chain_v[i]),
			.in_word   (chain_word[i]),
			.out_valid (chain_v[i+1]),
			.out_word  (chain_word[i+1])
		);
	end

	gtp_post u_post (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.in_valid          (chain_v[CORDIC_STAGES]),
		.in_word           (chain_word[CORDIC_STAGES]),
		.cruise_speed      (cruise_q),
		.heading_tolerance (htol_q),
		.out_valid         (out_valid),
		.linear_x          (linear_x),
		.angular_z         (angular_z),
		.mode              (mode_w)
	);

	assign mode = mode_w;

endmodule

`default_nettype wire

/* rtl/core/gtp_checker.sv */
// Port-level checks for go_to_point_steering, bound to the top level.
// Depends on gtp_pkg.
`default_nettype none

module gtp_checker import gtp_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_ready,
	input  wire logic                    out_valid,
	input  wire logic                    out_ready,
	input  wire logic [SPD_W-1:0]        linear_x,
	input  wire logic signed [RATE_W-1:0] angular_z,
	input  wire logic [MODE_W-1:0]       mode
);

	localparam logic signed [RATE_W-1:0] RLIM = RATE_W'(RATE_LIMIT);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(linear_x) &&
		$stable(angular_z) && $stable(mode))
		else $error("output word changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == MODE_ARRIVED |-> linear_x == '0 && angular_z == '0)
		else $error("arrived word carries motion");

	a_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == MODE_TURN |->
		linear_x == '0 && angular_z <= RLIM && angular_z >= -RLIM)
		else $error("turn word out of range or moving");

	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode == MODE_DRIVE |-> angular_z == '0)
		else $error("drive word turns");

endmodule

bind go_to_point_steering gtp_checker u_gtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.linear_x  (linear_x),
	.angular_z (angular_z),
	.mode      (mode)
);

`default_nettype wire

/* dv/tb.sv */
// Testbench for go_to_point_steering: poses in, velocity commands out, both on valid/ready.
// A scoreboard class predicts each command in the same fixed point as the block.
// Depends on gtp_pkg and go_to_point_steering.
`timescale 1ns / 1ps

module tb;
	import gtp_pkg::*;

	localparam longint PI_16      = 205887;
	localparam longint TWO_PI_16  = 411775;
	localparam longint HALF_PI_16 = 102944;
	localparam longint RATE_MAX   = 32170;
	localparam int     DRAIN_CYCLES = 30;
	localparam int     WATCHDOG     = 3000;

	typedef struct {
		logic [SPD_W-1:0]         lin;
		logic signed [RATE_W-1:0] ang;
		mode_t                    mode;
	} steer_cmd_t;

	class steer_scoreboard;
		longint goal_x, goal_y, cruise, dist_tol, head_tol;
		steer_cmd_t cmd_q[$];
		int poses_seen;
		int mismatches;
		longint atan_tab [0:16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};

		function new();
			goal_x = 0;
			goal_y = 0;
			cruise = 1024;
			dist_tol = 102;
			head_tol = 41;
			poses_seen = 0;
			mismatches = 0;
		endfunction

		// divide by a positive d, halves away from zero
		function longint div_round(longint v, longint d);
			if (v >= 0)
				return (v + d / 2) / d;
			return -((-v + d / 2) / d);
		endfunction

		// CORDIC vectoring, angle in Q16 radians
		function longint bearing(longint dx, longint dy);
			longint x, y, z, t, xs, ys;
			int i;
			if (dx == 0 && dy == 0)
				return 0;
			x = dx * 4096;
			y = dy * 4096;
			z = 0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = HALF_PI_16;
				end else begin
					t = x; x = -y; y = t; z = -HALF_PI_16;
				end
			end
			for (i = 0; i < CORDIC_STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += (i < 17) ? atan_tab[i] : 0;
				end else begin
					x -= ys; y += xs; z -= (i < 17) ? atan_tab[i] : 0;
				end
			end
			return z;
		endfunction

		function void note_pose(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
				logic signed [ANG_W-1:0] th);
			longint dx, dy, err, err12, mag, rate;
			steer_cmd_t cmd;
			poses_seen++;
			cmd.lin = '0;
			cmd.ang = '0;
			cmd.mode = MODE_ARRIVED;
			dx = goal_x - longint'(px);
			dy = goal_y - longint'(py);
			if (dx * dx + dy * dy < dist_tol * dist_tol) begin
				cmd_q.push_back(cmd);
				return;
			end
			err = bearing(dx, dy) - longint'(th) * 16;
			while (err > PI_16)
				err -= TWO_PI_16;
			while (err < -PI_16)
				err += TWO_PI_16;
			err12 = div_round(err, 16);
			mag = (err12 < 0) ? -err12 : err12;
			if (mag > head_tol) begin
				rate = div_round(err12 * TURN_GAIN, 4);
				if (rate > RATE_MAX)
					rate = RATE_MAX;
				if (rate < -RATE_MAX)
					rate = -RATE_MAX;
				cmd.ang = rate[RATE_W-1:0];
				cmd.mode = MODE_TURN;
			end else begin
				cmd.lin = cruise[SPD_W-1:0];
				cmd.mode = MODE_DRIVE;
			end
			cmd_q.push_back(cmd);
		endfunction

		task report_mismatch(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_command(logic [SPD_W-1:0] lin, logic signed [RATE_W-1:0] ang,
				logic [MODE_W-1:0] md);
			steer_cmd_t want;
			if (cmd_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word lin %0d ang %0d mode %0d",
					lin, ang, md));
				return;
			end
			want = cmd_q.pop_front();
			if (lin !== want.lin)
				report_mismatch($sformatf("linear_x %0d, want %0d", lin, want.lin));
			if (ang !== want.ang)
				report_mismatch($sformatf("angular_z %0d, want %0d", ang, want.ang));
			if (md !== want.mode)
				report_mismatch($sformatf("mode %0d, want %0d", md, want.mode));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [POS_W-1:0] pose_x;
	logic signed [POS_W-1:0] pose_y;
	logic signed [ANG_W-1:0] pose_theta;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SPD_W-1:0] linear_x;
	logic signed [RATE_W-1:0] angular_z;
	logic [MODE_W-1:0] mode;

	steer_scoreboard sb;
	bit no_idle = 1'b0;
	bit held = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	go_to_point_steering dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pose_x     (pose_x),
		.pose_y     (pose_y),
		.pose_theta (pose_theta),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.linear_x   (linear_x),
		.angular_z  (angular_z),
		.mode       (mode)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sink: random back-pressure, plus one long hold-off to fill the pipe
	always @(posedge clk) begin
		if (!held && sb.poses_seen >= 600) begin
			held = 1'b1;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= no_idle || ($urandom_range(99) >= 7);
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_pose(pose_x, pose_y, pose_theta);
			if (out_valid && out_ready)
				sb.check_command(linear_x, angular_z, mode);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	task automatic send_pose(longint x, longint y, longint th);
		while (!no_idle && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pose_x <= x[POS_W-1:0];
		pose_y <= y[POS_W-1:0];
		pose_theta <= th[ANG_W-1:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random_pose();
		longint x, y, th, r, b;
		int pick;
		pick = $urandom_range(99);
		x = longint'($signed(16'($urandom())));
		y = longint'($signed(16'($urandom())));
		th = longint'($signed(15'($urandom())));
		if (pick < 25) begin
			// anywhere, heading over the full field range
		end else if (pick < 45) begin
			// around the arrival radius
			r = clamp_to(sb.dist_tol * 3 / 2 + 4, 4, 40000);
			x = clamp_to(sb.goal_x + longint'($urandom_range(0, 2 * r)) - r, -32768, 32767);
			y = clamp_to(sb.goal_y + longint'($urandom_range(0, 2 * r)) - r, -32768, 32767);
		end else if (pick < 80) begin
			// heading close to the bearing, either side of the tolerance
			if (pick < 60) begin
				x = clamp_to(sb.goal_x + longint'($urandom_range(0, 4000)) - 2000, -32768, 32767);
				y = clamp_to(sb.goal_y + longint'($urandom_range(0, 4000)) - 2000, -32768, 32767);
			end
			r = clamp_to(sb.head_tol, 0, 400) + 3;
			b = sb.div_round(sb.bearing(sb.goal_x - x, sb.goal_y - y), 16);
			th = clamp_to(b + longint'($urandom_range(0, 2 * r)) - r, -16384, 16383);
		end else begin
			case ($urandom_range(3))
				0: x = -32768;
				1: x = 32767;
				2: x = sb.goal_x;
				default: ;
			endcase
			case ($urandom_range(3))
				0: y = -32768;
				1: y = 32767;
				2: y = sb.goal_y;
				default: ;
			endcase
			case ($urandom_range(5))
				0: th = -16384;
				1: th = 16383;
				2: th = 12868;
				3: th = -12868;
				4: th = 0;
				default: ;
			endcase
		end
		send_pose(x, y, th);
	endtask

	task automatic put_reg(cfg_reg_t r, longint v);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= v[CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	// only called with the pipe empty
	task automatic set_config(longint tx, longint ty, longint cs, longint dt, longint ht);
		put_reg(REG_TARGET_X, tx);
		put_reg(REG_TARGET_Y, ty);
		put_reg(REG_CRUISE, cs);
		put_reg(REG_DIST_TOL, dt);
		put_reg(REG_HEAD_TOL, ht);
		cfg_wr_en <= 1'b0;
		sb.goal_x = longint'($signed(tx[POS_W-1:0]));
		sb.goal_y = longint'($signed(ty[POS_W-1:0]));
		sb.cruise = longint'(cs[SPD_W-1:0]);
		sb.dist_tol = longint'(dt[TOL_W-1:0]);
		sb.head_tol = longint'(ht[HTOL_W-1:0]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.cmd_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int n);
		int k;
		for (k = 0; k < n; k++)
			send_random_pose();
	endtask

	initial begin
		int dir_pose [0:21][0:2] = '{
			'{0, 0, 0}, '{101, 0, 0}, '{102, 0, 0}, '{-102, 0, 0},
			'{-1024, 0, 41}, '{-1024, 0, 100}, '{-1024, 0, -100}, '{0, -1024, 6434},
			'{1024, 1024, 0}, '{1024, -1024, 0}, '{-32768, -32768, 12868},
			'{32767, 32767, -12868}, '{-32768, 32767, 16383}, '{32767, -32768, -16384},
			'{0, 32767, 0}, '{0, -32768, 0}, '{32767, 0, -16384}, '{-32768, 0, 16383},
			'{100, 100, 0}, '{72, 72, 0}, '{1024, 0, 12868}, '{1024, 0, -12868}};
		int p, k;
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pose_x = '0;
		pose_y = '0;
		pose_theta = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: boundaries of the radius, each quadrant, heading extremes
		for (k = 0; k < 22; k++)
			send_pose(dir_pose[k][0], dir_pose[k][1], dir_pose[k][2]);
		run_random(150);
		drain();

		for (p = 1; p < 8; p++) begin
			case (p)
				1: set_config(0, 0, 32767, 0, 0);
				2: set_config(32767, -32768, 0, 32767, 12868);
				3: set_config(-32768, 32767, 1, 1, 16383);  // tolerance above pi: never turns
				default: set_config($urandom(), $urandom(), $urandom_range(0, 32767),
					($urandom_range(3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3000),
					$urandom_range(0, 800));
			endcase
			no_idle = (p == 5);
			// pose on the goal (zero vector when the radius is zero) and on the radius
			send_pose(sb.goal_x, sb.goal_y, 0);
			send_pose(clamp_to(sb.goal_x + sb.dist_tol, -32768, 32767), sb.goal_y,
				$urandom_range(0, 2000));
			run_random(170);
			drain();
		end

		if (sb.cmd_q.size() != 0)
			sb.report_mismatch($sformatf("%0d words never arrived", sb.cmd_q.size()));
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
